// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the frequency meter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hdl/apfm_pkg.sv =====
// Package of the averaging frequency meter: widths, codes and link types.
// No dependencies; imported by every module of the block.
package apfm_pkg;

  localparam int CAP_W    = 16;
  localparam int CLK_W    = 25;
  localparam int PERIOD_W = 32;
  localparam int ACC_W    = 39;
  localparam int SUM_W    = 36;
  localparam int FREQ_W   = 33;
  localparam int OUT_W    = 72;

  localparam int          DEF_PERIODS = 10;
  localparam logic [CLK_W-1:0] CLK_RESET = 25'd7995392;
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Event kinds carried on tuser
  localparam logic KIND_CAPTURE  = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  // Front to queue: finished period sum
  typedef struct packed {
    logic             push;
    logic [ACC_W-1:0] sum;
  } push_t;

  // Queue to back: oldest queued sum
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] sum;
  } head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WRITE
  } bk_state_t;

endpackage

// ===== hdl/apfm_front.sv =====
// Front of the frequency meter: classifies events and accumulates periods.
// Depends on apfm_pkg; feeds finished sums to apfm_queue.
module apfm_front #(
  parameter int PERIODS_PER_RESULT = apfm_pkg::DEF_PERIODS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      kind,
  input  logic [apfm_pkg::CAP_W-1:0] capture_value,
  output apfm_pkg::push_t           push
);
  import apfm_pkg::*;

  localparam int DONE_W = $clog2(PERIODS_PER_RESULT + 1);

  logic              awaiting_r, awaiting_nxt;
  logic [CAP_W-1:0]  start_r, start_nxt;
  logic [CAP_W-1:0]  ovf_r, ovf_nxt;
  logic [DONE_W-1:0] done_r, done_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PERIOD_W-1:0] period;
  logic [ACC_W-1:0]  acc_sum;
  logic [DONE_W-1:0] done_inc;

  // overflow count sits above the end stamp; wrap modulo 2^32
  assign period   = {ovf_r, capture_value} - {{(PERIOD_W-CAP_W){1'b0}}, start_r};
  assign acc_sum  = acc_r + ACC_W'(period);
  assign done_inc = done_r + DONE_W'(1);

  always_comb begin
    awaiting_nxt = awaiting_r;
    start_nxt    = start_r;
    ovf_nxt      = ovf_r;
    done_nxt     = done_r;
    acc_nxt      = acc_r;
    push.push    = 1'b0;
    push.sum     = acc_sum;
    if (accept) begin
      if (kind == KIND_OVERFLOW) begin
        if (ovf_r != {CAP_W{1'b1}}) begin
          ovf_nxt = ovf_r + CAP_W'(1);
        end
      end else if (!awaiting_r) begin
        start_nxt    = capture_value;
        ovf_nxt      = '0;
        awaiting_nxt = 1'b1;
      end else begin
        awaiting_nxt = 1'b0;
        if (done_inc == DONE_W'(PERIODS_PER_RESULT)) begin
          push.push = 1'b1;
          acc_nxt   = '0;
          done_nxt  = '0;
          ovf_nxt   = '0;
        end else begin
          acc_nxt  = acc_sum;
          done_nxt = done_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      start_r    <= '0;
      ovf_r      <= '0;
      done_r     <= '0;
      acc_r      <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      start_r    <= start_nxt;
      ovf_r      <= ovf_nxt;
      done_r     <= done_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

// ===== hdl/apfm_queue.sv =====
// Two-entry queue of period sums between front and back of the meter.
// Depends on apfm_pkg.
module apfm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  apfm_pkg::push_t push,
  input  logic            pop,
  output apfm_pkg::head_t head,
  output logic            full
);
  import apfm_pkg::*;

  logic [ACC_W-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.sum   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push.push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      entry_r[wr_ptr_r] <= push.sum;
    end
  end

endmodule

// ===== hdl/apfm_back.sv =====
// Back of the frequency meter: restoring divider and output register.
// Depends on apfm_pkg; takes sums from apfm_queue.
module apfm_back #(
  parameter int PERIODS_PER_RESULT = apfm_pkg::DEF_PERIODS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [apfm_pkg::CLK_W-1:0]  clock_hz,
  input  apfm_pkg::head_t             head,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [apfm_pkg::OUT_W-1:0]  out_tdata
);
  import apfm_pkg::*;

  localparam int PW    = $clog2(PERIODS_PER_RESULT + 1);
  localparam int PROD_W = CLK_W + PW;
  localparam int NUM_W = PROD_W + 8;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int REM_W = ACC_W + 1;

  bk_state_t        st_r, st_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;
  logic [ACC_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             step, load_out;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0] rem_sh;
  logic             ge;
  logic             out_valid_r;
  logic [SUM_W-1:0] sum_out_r;
  logic [FREQ_W-1:0] freq_out_r;
  logic [SUM_W-1:0] sum_sat;
  logic [FREQ_W-1:0] freq_sat;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:  if (head.valid) st_nxt = BK_DIV;
      BK_DIV:   if (cnt_r == CNT_W'(1)) st_nxt = BK_WRITE;
      BK_WRITE: if (!out_valid_r || out_tready) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      BK_IDLE:  pop = head.valid;
      BK_DIV:   step = 1'b1;
      BK_WRITE: load_out = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign prod   = PROD_W'(clock_hz) * PROD_W'(PERIODS_PER_RESULT);
  assign rem_sh = {rem_r[ACC_W-1:0], quo_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});

  // one quotient bit per cycle; a zero divisor yields all ones, which saturates
  always_ff @(posedge clk) begin
    if (pop) begin
      quo_r <= {prod, 8'd0};
      rem_r <= '0;
      div_r <= head.sum;
      cnt_r <= CNT_W'(NUM_W);
    end else if (step) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign sum_sat  = (|div_r[ACC_W-1:SUM_W]) ? SUM_MAX : div_r[SUM_W-1:0];
  assign freq_sat = (|quo_r[NUM_W-1:FREQ_W]) ? FREQ_MAX : quo_r[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum_out_r  <= sum_sat;
      freq_out_r <= freq_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-SUM_W-FREQ_W){1'b0}}, freq_out_r, sum_out_r};

endmodule

// ===== hdl/averaging_period_frequency_meter_core.sv =====
// Averaging reciprocal frequency meter. Timer events arrive on the input
// stream: tuser 0 is an edge capture (tdata holds the 16-bit timer count),
// tuser 1 a timer overflow tick. Captures alternate between the start and
// the end of a period; a period is overflows*65536 + end - start, modulo
// 2^32. Every PERIODS_PER_RESULT periods one result leaves with the period
// sum (saturated to 36 bits) and clock_hz*PERIODS_PER_RESULT*256/sum in Q.8
// hertz (saturated to 33 bits; a zero sum saturates). The front takes one
// event per cycle while the two-entry sum queue has room. The back divides
// one quotient bit per cycle of a NUM_W-bit quotient, where NUM_W is
// 25 + clog2(PERIODS_PER_RESULT+1) + 8, and pops a sum only when idle.
// Write cfg_wr_data only while no group is in flight.
// Depends on apfm_pkg, apfm_front, apfm_queue, apfm_back, assert_macros.svh.
`include "assert_macros.svh"

module averaging_period_frequency_meter_core #(
  parameter int PERIODS_PER_RESULT = apfm_pkg::DEF_PERIODS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: timer clock in hertz
  input  logic                        cfg_wr_en,
  input  logic [apfm_pkg::CLK_W-1:0]  cfg_wr_data,
  // event requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [apfm_pkg::CAP_W-1:0]  in_tdata,   // [15:0] capture_value
  input  logic                        in_tuser,   // [0] kind
  // result requests
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [apfm_pkg::OUT_W-1:0]  out_tdata   // [35:0] period_sum, [68:36] frequency_q8
);
  import apfm_pkg::*;

  logic [CLK_W-1:0] clock_hz_r;
  logic             accept;
  logic             q_full;
  logic             pop;
  push_t            push;
  head_t            head;

  // hold the timer clock frequency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLK_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  // stall every event while the sum queue is full
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  apfm_front #(
    .PERIODS_PER_RESULT(PERIODS_PER_RESULT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .kind         (in_tuser),
    .capture_value(in_tdata),
    .push         (push)
  );

  apfm_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  apfm_back #(
    .PERIODS_PER_RESULT(PERIODS_PER_RESULT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_hz  (clock_hz_r),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push.push && q_full, "sum pushed into full queue")
  `ASSERT_NEVER(a_no_pop_when_empty, clk, rst_n, pop && !head.valid, "pop from empty queue")
  `ASSERT_CLK(a_zero_sum_saturates, clk, rst_n, (out_tvalid && (out_tdata[35:0] == 36'd0)) |-> (out_tdata[68:36] == FREQ_MAX), "zero sum must saturate frequency")

endmodule

// ===== test/averaging_period_frequency_meter_core_tb.sv =====
// Self-checking testbench for the averaging reciprocal frequency meter core.
// Drives timer events, predicts every period-sum/frequency result and checks it.
// Depends on apfm_pkg and averaging_period_frequency_meter_core.
`timescale 1ns / 1ps

module averaging_period_frequency_meter_core_tb;
  import apfm_pkg::*;

  localparam int METER_PERIODS = DEF_PERIODS;
  // Give the divider margin to finish before config writes.
  localparam int DRAIN_CYCLES  = 64;
  // Cycle limit for a full run, including the long receiver hold-off.
  localparam int CYCLE_LIMIT   = 100000;
  localparam int MAX_PRINTED   = 50;

  typedef struct {
    logic [SUM_W-1:0]  sum;
    logic [FREQ_W-1:0] freq;
  } meter_reading_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [CLK_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [CAP_W-1:0]  in_tdata    = '0;   // [15:0] capture_value
  logic              in_tuser    = 1'b0; // [0] kind
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;          // [35:0] period_sum, [68:36] frequency_q8

  // Predicted meter state, mirrored from the block's behavior
  logic [CLK_W-1:0]  meter_clock_hz       = CLK_RESET;
  logic              meter_awaiting_end   = 1'b0;
  logic [CAP_W-1:0]  meter_start_stamp    = '0;
  logic [15:0]       meter_overflow_count = '0;
  int                meter_periods_done   = 0;
  logic [ACC_W-1:0]  meter_tick_acc       = '0;

  meter_reading_t    pending_readings[$];

  int  error_count       = 0;
  int  cycle_count       = 0;
  int  events_sent       = 0;
  int  readings_expected = 0;
  int  recv_hold_left    = 0;
  bit  send_no_idle      = 1'b0;
  bit  recv_no_idle      = 1'b0;

  averaging_period_frequency_meter_core #(
    .PERIODS_PER_RESULT(METER_PERIODS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s: got %0d, expected %0d",
               cycle_count, what, got, want);
  endtask

  // Advance the predicted state by one accepted event; queue a reading when
  // a group of periods completes.
  function automatic void predict_meter_event(input logic kind, input logic [CAP_W-1:0] cap);
    logic [PERIOD_W-1:0] period;
    logic [63:0]         numerator;
    logic [63:0]         quotient;
    meter_reading_t      reading;
    // Overflow ticks only count, saturating at the 16-bit maximum.
    if (kind == KIND_OVERFLOW) begin
      if (meter_overflow_count != 16'hFFFF)
        meter_overflow_count++;
      return;
    end
    // A start capture stamps the period and drops any overflows seen so far.
    if (!meter_awaiting_end) begin
      meter_start_stamp    = cap;
      meter_overflow_count = '0;
      meter_awaiting_end   = 1'b1;
      return;
    end
    // End capture: period wraps modulo 2^32, accumulator modulo 2^39.
    period = {meter_overflow_count, 16'h0000} + PERIOD_W'(cap) - PERIOD_W'(meter_start_stamp);
    meter_tick_acc     = meter_tick_acc + ACC_W'(period);
    meter_periods_done++;
    meter_awaiting_end = 1'b0;
    if (meter_periods_done < METER_PERIODS)
      return;
    reading.sum = (meter_tick_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : meter_tick_acc[SUM_W-1:0];
    if (meter_tick_acc == '0) begin
      reading.freq = FREQ_MAX;
    end else begin
      numerator    = 64'(meter_clock_hz) * 64'(METER_PERIODS) * 64'd256;
      quotient     = numerator / 64'(meter_tick_acc);
      reading.freq = (quotient > 64'(FREQ_MAX)) ? FREQ_MAX : quotient[FREQ_W-1:0];
    end
    pending_readings.push_back(reading);
    readings_expected++;
    meter_tick_acc       = '0;
    meter_periods_done   = 0;
    meter_overflow_count = '0;
  endfunction

  // Offer one event request and hold it until the block takes it. Handshakes
  // are sampled at the falling edge, where every signal is settled.
  task automatic send_event(input logic kind, input logic [CAP_W-1:0] cap);
    bit taken;
    if (!send_no_idle) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= cap;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    events_sent++;
    predict_meter_event(kind, cap);
  endtask

  task automatic send_period(input logic [CAP_W-1:0] start_cap, input int ticks,
                             input logic [CAP_W-1:0] end_cap);
    send_event(KIND_CAPTURE, start_cap);
    repeat (ticks) send_event(KIND_OVERFLOW, CAP_W'($urandom));
    send_event(KIND_CAPTURE, end_cap);
  endtask

  // Drop valid, wait for every expected reading, then let the divider go quiet.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    meter_clock_hz  = value;
  endtask

  // Receiver: random stalls, a hold-off counted here when requested.
  always @(posedge clk) begin
    if (recv_hold_left > 0) begin
      out_tready    <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_tready <= recv_no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Check each accepted result request against the oldest prediction.
  always @(negedge clk) begin : check_readings
    meter_reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_tdata[SUM_W-1:0]), 64'd0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[SUM_W-1:0] !== want.sum)
          report_mismatch("period_sum", 64'(out_tdata[SUM_W-1:0]), 64'(want.sum));
        if (out_tdata[SUM_W +: FREQ_W] !== want.freq)
          report_mismatch("frequency_q8", 64'(out_tdata[SUM_W +: FREQ_W]), 64'(want.freq));
      end
    end
  end

  // One group at the reset clock: full-range period, wrap without overflow,
  // exactly one overflow, overflow ticks between periods, zero periods.
  task automatic test_corner_periods();
    send_period(16'h0000, 0, 16'hFFFF);
    send_period(16'hFFFF, 0, 16'h0000);
    send_period(16'h1234, 1, 16'h1234);
    send_event(KIND_OVERFLOW, 16'hFFFF);
    send_event(KIND_OVERFLOW, 16'h0000);
    send_period(16'h8000, 0, 16'h8001);
    repeat (METER_PERIODS - 4) send_period(16'h5555, 0, 16'h5555);
    settle_block();
  endtask

  // All periods zero: the frequency saturates.
  task automatic test_zero_sum();
    logic [CAP_W-1:0] stamp;
    write_clock('1);
    repeat (METER_PERIODS) begin
      stamp = CAP_W'($urandom);
      send_period(stamp, 0, stamp);
    end
    settle_block();
  endtask

  // Sum of one tick at the largest clock: the quotient overflows 33 bits.
  task automatic test_large_quotient();
    send_period(16'hAAAA, 0, 16'hAAAB);
    repeat (METER_PERIODS - 1) send_period(16'h0F0F, 0, 16'h0F0F);
    settle_block();
  endtask

  // Clock of zero: frequency is zero, unless the sum is zero too.
  task automatic test_zero_clock();
    write_clock('0);
    repeat (METER_PERIODS) send_period(CAP_W'($urandom), $urandom_range(2), CAP_W'($urandom));
    repeat (METER_PERIODS) send_period(16'h00FF, 0, 16'h00FF);
    settle_block();
  endtask

  // Count a long run of overflow ticks inside a single period.
  task automatic test_many_overflows();
    write_clock(CLK_RESET);
    send_no_idle = 1'b1;
    send_period(16'h0000, 40, 16'h0000);
    send_no_idle = 1'b0;
    repeat (METER_PERIODS - 1) send_period(16'hC000, 0, 16'h4000);
    settle_block();
  endtask

  // Hold the receiver off while the sender streams groups back to back, so
  // the sum queue fills and the input stalls.
  task automatic test_backpressure();
    write_clock(CLK_W'($urandom_range(33554431, 1)));
    recv_hold_left = 1500;
    send_no_idle   = 1'b1;
    repeat (6 * METER_PERIODS) send_period(CAP_W'($urandom), $urandom_range(1), CAP_W'($urandom));
    send_no_idle   = 1'b0;
    settle_block();
  endtask

  // One mostly well-formed period with random content; stray overflow ticks
  // and stray captures act as noise.
  task automatic send_random_period();
    logic [CAP_W-1:0] start_cap;
    logic [CAP_W-1:0] end_cap;
    int               ticks;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 15)
      repeat ($urandom_range(3, 1)) send_event(KIND_OVERFLOW, CAP_W'($urandom));
    else if (roll < 18)
      send_event(KIND_CAPTURE, CAP_W'($urandom));
    roll = $urandom_range(99);
    start_cap = (roll < 5) ? 16'hFFFF : (roll < 10) ? 16'h0000 : CAP_W'($urandom);
    roll  = $urandom_range(99);
    ticks = (roll < 60) ? 0 : (roll < 85) ? $urandom_range(2, 1) : $urandom_range(6, 3);
    roll  = $urandom_range(99);
    if (roll < 10)
      end_cap = start_cap;
    else if (roll < 25)
      end_cap = start_cap + CAP_W'($urandom_range(3, 1));
    else
      end_cap = CAP_W'($urandom);
    send_period(start_cap, ticks, end_cap);
  endtask

  // Random traffic over several clock settings; the last phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    int events_at_start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_clock('1);
        1: write_clock(CLK_W'(1));
        2: write_clock(CLK_W'($urandom_range(33554431, 1)));
        default: write_clock(CLK_RESET);
      endcase
      send_no_idle    = (phase == 3);
      recv_no_idle    = (phase == 3);
      events_at_start = events_sent;
      while (events_sent - events_at_start < 175)
        send_random_period();
      send_no_idle = 1'b0;
      recv_no_idle = 1'b0;
      settle_block();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_periods();
    test_zero_sum();
    test_large_quotient();
    test_zero_clock();
    test_many_overflows();
    test_backpressure();
    test_random_traffic();

    if (pending_readings.size() != 0)
      report_mismatch("results never arrived", 64'(pending_readings.size()), 64'd0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
